FILE: design/bfq_pkg.sv
// shared types and constants for the bounded fifo with queries
package bfq_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned EntriesW = 11;

  localparam logic signed [WordW-1:0] NoneWord = -32'sd1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

FILE: design/bounded_fifo_with_queries.sv
// top level of the bounded fifo with queries
//
// Input channel (in_valid_i / in_ready_o) carries one operation per item:
// push value_i, pop the front word, or query (op code 3 acts as a query).
// Output channel (out_valid_o / out_ready_i) returns exactly one result per
// item: popped word and pop_done, overflow for a dropped push, entry count,
// empty flag, and the front and back words after the operation (-1 when
// the queue is empty).
// Storage is a row of DEPTH cells; the front sits in cell 0, a pop
// shifts every cell one place toward the front and a push fills the
// first free cell.
// The result is registered; it appears in the cycle after acceptance.
// Throughput: one item per cycle while out_ready_i is high; the result
// register frees up in the same cycle it is taken.
// When the receiver stalls, the result holds and in_ready_o drops until it
// is taken. Reset empties the queue and clears the pending result.
module bounded_fifo_with_queries #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [1:0]                              op_i,
  input  logic signed [bfq_pkg::WordW-1:0]        value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [bfq_pkg::WordW-1:0]        popped_o,
  output logic                                    pop_done_o,
  output logic                                    overflow_o,
  output logic [bfq_pkg::EntriesW-1:0]            entries_o,
  output logic                                    is_empty_o,
  output logic signed [bfq_pkg::WordW-1:0]        front_word_o,
  output logic signed [bfq_pkg::WordW-1:0]        back_word_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                               cell_valid [DEPTH];
  logic signed [bfq_pkg::WordW-1:0]   cell_data  [DEPTH];
  bfq_pkg::cell_ctl_t                 ctl;

  logic [CntW-1:0]                    count_q, count_d;
  logic signed [bfq_pkg::WordW-1:0]   back_q, back_d;

  logic                               accept, is_full, is_emp;
  logic                               is_push, is_pop;
  logic                               do_push, do_pop;

  logic                               out_valid_q;
  logic signed [bfq_pkg::WordW-1:0]   popped_q, popped_d;
  logic                               pop_done_q, overflow_q, overflow_d;
  logic [bfq_pkg::EntriesW-1:0]       entries_q;
  logic                               is_empty_q;
  logic signed [bfq_pkg::WordW-1:0]   front_q, front_d;
  logic signed [bfq_pkg::WordW-1:0]   back_out_q, back_out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CntW'(DEPTH));
  assign is_emp     = (count_q == '0);

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    case (op_i)
      bfq_pkg::OP_PUSH:  is_push = 1'b1;
      bfq_pkg::OP_POP:   is_pop  = 1'b1;
      bfq_pkg::OP_QUERY: ;
      default:           ;
    endcase
  end

  assign do_push  = accept && is_push && !is_full;
  assign do_pop   = accept && is_pop && !is_emp;
  assign ctl.push = do_push;
  assign ctl.pop  = do_pop;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                               prev_valid;
    logic                               next_valid;
    logic signed [bfq_pkg::WordW-1:0]   next_data;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_data  = bfq_pkg::NoneWord;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_data  = cell_data[i+1];
    end

    bfq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .value_i      (value_i),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_data_i  (next_data),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign back_d = do_push ? value_i : back_q;

  // result fields as seen after the operation
  always_comb begin
    popped_d   = do_pop ? cell_data[0] : bfq_pkg::NoneWord;
    overflow_d = accept && is_push && is_full;
    if (count_d == '0) begin
      front_d    = bfq_pkg::NoneWord;
      back_out_d = bfq_pkg::NoneWord;
    end else begin
      back_out_d = back_d;
      if (do_push && is_emp) begin
        front_d = value_i;
      end else if (do_pop) begin
        front_d = cell_data[1];
      end else begin
        front_d = cell_data[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    back_q <= back_d;
    if (accept) begin
      popped_q   <= popped_d;
      pop_done_q <= do_pop;
      overflow_q <= overflow_d;
      entries_q  <= bfq_pkg::EntriesW'(count_d);
      is_empty_q <= (count_d == '0);
      front_q    <= front_d;
      back_out_q <= back_out_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign popped_o     = popped_q;
  assign pop_done_o   = pop_done_q;
  assign overflow_o   = overflow_q;
  assign entries_o    = entries_q;
  assign is_empty_o   = is_empty_q;
  assign front_word_o = front_q;
  assign back_word_o  = back_out_q;

endmodule

FILE: design/bfq_cell.sv
// one storage cell of the shifting queue chain
module bfq_cell (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  bfq_pkg::cell_ctl_t                      ctl_i,
  input  logic signed [bfq_pkg::WordW-1:0]        value_i,
  input  logic                                    prev_valid_i,
  input  logic                                    next_valid_i,
  input  logic signed [bfq_pkg::WordW-1:0]        next_data_i,
  output logic                                    valid_o,
  output logic signed [bfq_pkg::WordW-1:0]        data_o
);

  logic                               valid_q, valid_d;
  logic signed [bfq_pkg::WordW-1:0]   data_q, data_d;
  logic                               load;

  // first free cell takes the pushed word
  assign load = ctl_i.push && !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctl_i.pop) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (load) begin
      valid_d = 1'b1;
      data_d  = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: design/bfq_checker.sv
// port-level assertions for the bounded fifo with queries, bound to the top
module bfq_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  logic                                    in_ready_o,
  input  logic [1:0]                              op_i,
  input  logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  input  logic signed [bfq_pkg::WordW-1:0]        popped_o,
  input  logic                                    pop_done_o,
  input  logic                                    overflow_o,
  input  logic [bfq_pkg::EntriesW-1:0]            entries_o,
  input  logic                                    is_empty_o,
  input  logic signed [bfq_pkg::WordW-1:0]        front_word_o,
  input  logic signed [bfq_pkg::WordW-1:0]        back_word_o
);

  // every accepted item produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted item");

  // a stalled result is not dropped
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(front_word_o))
    else $error("stalled result changed");

  // empty queue reports no words and zero count
  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |->
      entries_o == '0 && front_word_o == bfq_pkg::NoneWord &&
      back_word_o == bfq_pkg::NoneWord)
    else $error("empty result carries words");

  // no popped word without a pop; the both-set term is only checked when pop_done_o is low
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pop_done_o |->
      popped_o == bfq_pkg::NoneWord && !(pop_done_o && overflow_o))
    else $error("inconsistent pop flags");

  // an op code other than push never reports overflow
  a_overflow_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i != bfq_pkg::OP_PUSH |=> !overflow_o)
    else $error("overflow on non-push item");

endmodule

bind bounded_fifo_with_queries bfq_checker u_bfq_checker (.*);
